@@ sv/assert_macros.svh @@
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPI_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SPI_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ sv/spi_pkg.sv @@
// Package with shared constants and relation codes of the segment intersection unit.
`timescale 1ns / 1ps
package spi_pkg;
    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int OUT_BITS       = 32;
    localparam int REL_BITS       = 2;

    localparam logic [REL_BITS-1:0] REL_NONE    = 2'd0;
    localparam logic [REL_BITS-1:0] REL_POINT   = 2'd1;
    localparam logic [REL_BITS-1:0] REL_OVERLAP = 2'd2;
endpackage

@@ sv/spi_if.sv @@
// Valid/ready channel interfaces for segment pairs and intersection results.
`timescale 1ns / 1ps
interface spi_in_if #(parameter int CW = spi_pkg::COORD_BITS_DEF);
    logic valid;
    logic ready;
    logic signed [CW-1:0] a_start_x;
    logic signed [CW-1:0] a_start_y;
    logic signed [CW-1:0] a_end_x;
    logic signed [CW-1:0] a_end_y;
    logic signed [CW-1:0] b_start_x;
    logic signed [CW-1:0] b_start_y;
    logic signed [CW-1:0] b_end_x;
    logic signed [CW-1:0] b_end_y;
    modport source(output valid, a_start_x, a_start_y, a_end_x, a_end_y,
                   b_start_x, b_start_y, b_end_x, b_end_y, input ready);
    modport sink(input valid, a_start_x, a_start_y, a_end_x, a_end_y,
                 b_start_x, b_start_y, b_end_x, b_end_y, output ready);
endinterface

interface spi_out_if;
    logic valid;
    logic ready;
    logic [spi_pkg::REL_BITS-1:0] relation;
    logic signed [spi_pkg::OUT_BITS-1:0] first_x;
    logic signed [spi_pkg::OUT_BITS-1:0] first_y;
    logic signed [spi_pkg::OUT_BITS-1:0] second_x;
    logic signed [spi_pkg::OUT_BITS-1:0] second_y;
    modport source(output valid, relation, first_x, first_y, second_x, second_y,
                   input ready);
    modport sink(input valid, relation, first_x, first_y, second_x, second_y,
                 output ready);
endinterface

@@ sv/segment_pair_intersect_unit.sv @@
// Throughput: one segment pair per cycle while the output register can take data;
// the divider is a restoring divider unrolled into FRAC_BITS pipeline stages,
// one quotient bit per stage.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
// Reset (synchronous, active low) clears only the stage valid bits.
`timescale 1ns / 1ps
module segment_pair_intersect_unit #(
    parameter int COORD_BITS = spi_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = spi_pkg::FRAC_BITS_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    spi_in_if.sink     i_in,
    spi_out_if.source  o_out
);
    localparam int CW  = COORD_BITS;
    localparam int DW  = CW + 1;
    localparam int PW  = 2 * DW;
    localparam int XW  = PW + 1;
    localparam int NW  = XW - 1;
    localparam int FW  = FRAC_BITS + 1;
    localparam int MW  = FW + 1 + DW;
    localparam int OB  = spi_pkg::OUT_BITS;
    localparam int SW  = (CW + FRAC_BITS + 4 > OB) ? CW + FRAC_BITS + 4 : OB;
    localparam int NST = FRAC_BITS;

    typedef struct packed {
        logic signed [CW-1:0] ax, ay, bx, by, cx, cy, ex, ey;
    } t_pts;

    typedef struct packed {
        logic signed [DW-1:0] ux, uy, vx, vy, wx, wy, bcx, bcy;
    } t_dif;

    typedef struct packed {
        t_pts pts;
        t_dif dif;
    } t_s1;

    typedef struct packed {
        t_pts pts;
        t_dif dif;
        logic signed [PW-1:0] uxvy, uyvx, uxwy, uywx, vxwy, vywx;
    } t_s2;

    typedef struct packed {
        t_pts pts;
        t_dif dif;
        logic signed [XW-1:0] d, cuw, cvw;
    } t_s3;

    typedef struct packed {
        logic signed [CW-1:0] ax, ay, cx, cy;
        logic signed [DW-1:0] ux, uy, vx, vy;
        logic par, col_bad, upt, vpt, eq_ac, in_b, in_a;
        logic signed [XW-1:0] cn0, cn1, cdn, sn, tn, dd;
    } t_s4;

    typedef struct packed {
        logic [spi_pkg::REL_BITS-1:0] rel;
        logic signed [CW-1:0] base_x, base_y;
        logic signed [DW-1:0] dir_x, dir_y;
        logic [NW-1:0] den, rem0, rem1;
        logic full0, full1;
        logic [FRAC_BITS-1:0] q0, q1;
    } t_dv;

    typedef struct packed {
        logic [spi_pkg::REL_BITS-1:0] rel;
        logic signed [CW-1:0] base_x, base_y;
        logic signed [MW-1:0] p0x, p0y, p1x, p1y;
    } t_ml;

    function automatic logic on_span(input logic signed [CW-1:0] sx, sy, ex, ey, px, py);
        if (sx != ex) begin
            return (sx <= px && px <= ex) || (sx >= px && px >= ex);
        end
        return (sy <= py && py <= ey) || (sy >= py && py >= ey);
    endfunction

    logic adv;
    logic r_v1, r_v2, r_v3, r_v4, r_vm, r_vo;
    logic [NST:0] r_dvld;
    t_s1 r_s1, n_s1;
    t_s2 r_s2, n_s2;
    t_s3 r_s3, n_s3;
    t_s4 r_s4, n_s4;
    t_dv r_ds [NST+1];
    t_dv n_ds [NST+1];
    t_ml r_ml, n_ml;
    logic [spi_pkg::REL_BITS-1:0] r_rel;
    logic signed [OB-1:0] r_fx, r_fy, r_sx, r_sy;
    logic [spi_pkg::REL_BITS-1:0] n_rel;
    logic signed [OB-1:0] n_fx, n_fy, n_sx, n_sy;

    // The pipeline moves as a whole whenever the output register can take data.
    assign adv         = !r_vo || o_out.ready;
    assign i_in.ready  = adv;

    // Stage 1: register endpoints, direction vectors and endpoint offsets.
    always_comb begin
        n_s1.pts.ax = i_in.a_start_x;
        n_s1.pts.ay = i_in.a_start_y;
        n_s1.pts.bx = i_in.a_end_x;
        n_s1.pts.by = i_in.a_end_y;
        n_s1.pts.cx = i_in.b_start_x;
        n_s1.pts.cy = i_in.b_start_y;
        n_s1.pts.ex = i_in.b_end_x;
        n_s1.pts.ey = i_in.b_end_y;
        n_s1.dif.ux  = DW'(i_in.a_end_x) - DW'(i_in.a_start_x);
        n_s1.dif.uy  = DW'(i_in.a_end_y) - DW'(i_in.a_start_y);
        n_s1.dif.vx  = DW'(i_in.b_end_x) - DW'(i_in.b_start_x);
        n_s1.dif.vy  = DW'(i_in.b_end_y) - DW'(i_in.b_start_y);
        n_s1.dif.wx  = DW'(i_in.a_start_x) - DW'(i_in.b_start_x);
        n_s1.dif.wy  = DW'(i_in.a_start_y) - DW'(i_in.b_start_y);
        n_s1.dif.bcx = DW'(i_in.a_end_x) - DW'(i_in.b_start_x);
        n_s1.dif.bcy = DW'(i_in.a_end_y) - DW'(i_in.b_start_y);
    end

    // Stage 2: the six partial products of the three cross products.
    always_comb begin
        n_s2.pts  = r_s1.pts;
        n_s2.dif  = r_s1.dif;
        n_s2.uxvy = r_s1.dif.ux * r_s1.dif.vy;
        n_s2.uyvx = r_s1.dif.uy * r_s1.dif.vx;
        n_s2.uxwy = r_s1.dif.ux * r_s1.dif.wy;
        n_s2.uywx = r_s1.dif.uy * r_s1.dif.wx;
        n_s2.vxwy = r_s1.dif.vx * r_s1.dif.wy;
        n_s2.vywx = r_s1.dif.vy * r_s1.dif.wx;
    end

    // Stage 3: cross products.
    always_comb begin
        n_s3.pts = r_s2.pts;
        n_s3.dif = r_s2.dif;
        n_s3.d   = XW'(r_s2.uxvy) - XW'(r_s2.uyvx);
        n_s3.cuw = XW'(r_s2.uxwy) - XW'(r_s2.uywx);
        n_s3.cvw = XW'(r_s2.vxwy) - XW'(r_s2.vywx);
    end

    // Stage 4: degenerate-case flags and sign normalization of the fractions.
    always_comb begin
        logic signed [XW-1:0] t_n0, t_n1, t_dn;
        logic sel_x;
        sel_x = (r_s3.dif.vx != '0);
        t_n0  = sel_x ? XW'(r_s3.dif.wx)  : XW'(r_s3.dif.wy);
        t_n1  = sel_x ? XW'(r_s3.dif.bcx) : XW'(r_s3.dif.bcy);
        t_dn  = sel_x ? XW'(r_s3.dif.vx)  : XW'(r_s3.dif.vy);
        n_s4.ax = r_s3.pts.ax;
        n_s4.ay = r_s3.pts.ay;
        n_s4.cx = r_s3.pts.cx;
        n_s4.cy = r_s3.pts.cy;
        n_s4.ux = r_s3.dif.ux;
        n_s4.uy = r_s3.dif.uy;
        n_s4.vx = r_s3.dif.vx;
        n_s4.vy = r_s3.dif.vy;
        n_s4.par     = (r_s3.d == '0);
        n_s4.col_bad = (r_s3.cuw != '0) || (r_s3.cvw != '0);
        n_s4.upt     = (r_s3.dif.ux == '0) && (r_s3.dif.uy == '0);
        n_s4.vpt     = (r_s3.dif.vx == '0) && (r_s3.dif.vy == '0);
        n_s4.eq_ac   = (r_s3.pts.ax == r_s3.pts.cx) && (r_s3.pts.ay == r_s3.pts.cy);
        n_s4.in_b    = on_span(r_s3.pts.cx, r_s3.pts.cy, r_s3.pts.ex, r_s3.pts.ey,
                               r_s3.pts.ax, r_s3.pts.ay);
        n_s4.in_a    = on_span(r_s3.pts.ax, r_s3.pts.ay, r_s3.pts.bx, r_s3.pts.by,
                               r_s3.pts.cx, r_s3.pts.cy);
        n_s4.cn0 = (t_dn < 0) ? -t_n0 : t_n0;
        n_s4.cn1 = (t_dn < 0) ? -t_n1 : t_n1;
        n_s4.cdn = (t_dn < 0) ? -t_dn : t_dn;
        n_s4.dd  = (r_s3.d < 0) ? -r_s3.d   : r_s3.d;
        n_s4.sn  = (r_s3.d < 0) ? -r_s3.cvw : r_s3.cvw;
        n_s4.tn  = (r_s3.d < 0) ? -r_s3.cuw : r_s3.cuw;
    end

    // Stage 5: classification, clipping and divider operand selection.
    always_comb begin
        logic signed [XW-1:0] lo, hi, lo_c, hi_c;
        logic [NW-1:0] num0, num1, den;
        logic disj, skew_ok;
        lo      = (r_s4.cn0 > r_s4.cn1) ? r_s4.cn1 : r_s4.cn0;
        hi      = (r_s4.cn0 > r_s4.cn1) ? r_s4.cn0 : r_s4.cn1;
        disj    = (lo > r_s4.cdn) || (hi < 0);
        lo_c    = (lo < 0) ? '0 : lo;
        hi_c    = (hi > r_s4.cdn) ? r_s4.cdn : hi;
        skew_ok = (r_s4.sn >= 0) && (r_s4.sn <= r_s4.dd) &&
                  (r_s4.tn >= 0) && (r_s4.tn <= r_s4.dd);
        num0 = '0;
        num1 = '0;
        den  = NW'(1);
        n_ds[0].rel    = spi_pkg::REL_NONE;
        n_ds[0].base_x = r_s4.ax;
        n_ds[0].base_y = r_s4.ay;
        n_ds[0].dir_x  = '0;
        n_ds[0].dir_y  = '0;
        if (r_s4.par) begin
            if (r_s4.col_bad) begin
                n_ds[0].rel = spi_pkg::REL_NONE;
            end else if (r_s4.upt && r_s4.vpt) begin
                n_ds[0].rel = r_s4.eq_ac ? spi_pkg::REL_POINT : spi_pkg::REL_NONE;
            end else if (r_s4.upt) begin
                n_ds[0].rel = r_s4.in_b ? spi_pkg::REL_POINT : spi_pkg::REL_NONE;
            end else if (r_s4.vpt) begin
                n_ds[0].rel    = r_s4.in_a ? spi_pkg::REL_POINT : spi_pkg::REL_NONE;
                n_ds[0].base_x = r_s4.cx;
                n_ds[0].base_y = r_s4.cy;
            end else begin
                // Collinear: the parameter interval of A along B, clipped to 0..1.
                n_ds[0].base_x = r_s4.cx;
                n_ds[0].base_y = r_s4.cy;
                n_ds[0].dir_x  = r_s4.vx;
                n_ds[0].dir_y  = r_s4.vy;
                num0 = lo_c[NW-1:0];
                num1 = hi_c[NW-1:0];
                den  = r_s4.cdn[NW-1:0];
                if (disj) begin
                    n_ds[0].rel = spi_pkg::REL_NONE;
                end else if (lo_c == hi_c) begin
                    n_ds[0].rel = spi_pkg::REL_POINT;
                end else begin
                    n_ds[0].rel = spi_pkg::REL_OVERLAP;
                end
            end
        end else begin
            n_ds[0].rel   = skew_ok ? spi_pkg::REL_POINT : spi_pkg::REL_NONE;
            n_ds[0].dir_x = r_s4.ux;
            n_ds[0].dir_y = r_s4.uy;
            num0 = r_s4.sn[NW-1:0];
            den  = r_s4.dd[NW-1:0];
        end
        n_ds[0].den   = den;
        n_ds[0].rem0  = num0;
        n_ds[0].rem1  = num1;
        n_ds[0].full0 = (num0 >= den);
        n_ds[0].full1 = (num1 >= den);
        n_ds[0].q0    = '0;
        n_ds[0].q1    = '0;
    end

    // Restoring division, one quotient bit per stage for both fractions.
    for (genvar k = 1; k <= NST; k++) begin : g_div
        always_comb begin
            logic [NW:0] r2a, r2b;
            logic ga, gb;
            n_ds[k] = r_ds[k-1];
            r2a = {r_ds[k-1].rem0, 1'b0};
            r2b = {r_ds[k-1].rem1, 1'b0};
            ga  = (r2a >= {1'b0, r_ds[k-1].den});
            gb  = (r2b >= {1'b0, r_ds[k-1].den});
            n_ds[k].rem0 = ga ? NW'(r2a - {1'b0, r_ds[k-1].den}) : r2a[NW-1:0];
            n_ds[k].rem1 = gb ? NW'(r2b - {1'b0, r_ds[k-1].den}) : r2b[NW-1:0];
            n_ds[k].q0   = {r_ds[k-1].q0[FRAC_BITS-2:0], ga};
            n_ds[k].q1   = {r_ds[k-1].q1[FRAC_BITS-2:0], gb};
        end
    end

    // Multiply stage: fraction times direction vector.
    always_comb begin
        logic signed [FW:0] f0, f1;
        f0 = r_ds[NST].full0 ? $signed({2'b01, {FRAC_BITS{1'b0}}})
                             : $signed({2'b00, r_ds[NST].q0});
        f1 = r_ds[NST].full1 ? $signed({2'b01, {FRAC_BITS{1'b0}}})
                             : $signed({2'b00, r_ds[NST].q1});
        n_ml.rel    = r_ds[NST].rel;
        n_ml.base_x = r_ds[NST].base_x;
        n_ml.base_y = r_ds[NST].base_y;
        n_ml.p0x    = f0 * r_ds[NST].dir_x;
        n_ml.p0y    = f0 * r_ds[NST].dir_y;
        n_ml.p1x    = f1 * r_ds[NST].dir_x;
        n_ml.p1y    = f1 * r_ds[NST].dir_y;
    end

    // Output stage: start point in fixed point plus offset, wrapped to 32 bits.
    always_comb begin
        logic signed [SW-1:0] bx, by, s0x, s0y, s1x, s1y;
        bx  = $signed({{(SW-CW-FRAC_BITS){r_ml.base_x[CW-1]}}, r_ml.base_x,
                       {FRAC_BITS{1'b0}}});
        by  = $signed({{(SW-CW-FRAC_BITS){r_ml.base_y[CW-1]}}, r_ml.base_y,
                       {FRAC_BITS{1'b0}}});
        s0x = bx + SW'(r_ml.p0x);
        s0y = by + SW'(r_ml.p0y);
        s1x = bx + SW'(r_ml.p1x);
        s1y = by + SW'(r_ml.p1y);
        n_rel = r_ml.rel;
        n_fx  = (r_ml.rel != spi_pkg::REL_NONE) ? s0x[OB-1:0] : '0;
        n_fy  = (r_ml.rel != spi_pkg::REL_NONE) ? s0y[OB-1:0] : '0;
        n_sx  = (r_ml.rel == spi_pkg::REL_OVERLAP) ? s1x[OB-1:0] : '0;
        n_sy  = (r_ml.rel == spi_pkg::REL_OVERLAP) ? s1y[OB-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1     <= n_s1;
            r_s2     <= n_s2;
            r_s3     <= n_s3;
            r_s4     <= n_s4;
            for (int k = 0; k <= NST; k++) begin
                r_ds[k] <= n_ds[k];
            end
            r_ml     <= n_ml;
            r_rel    <= n_rel;
            r_fx     <= n_fx;
            r_fy     <= n_fy;
            r_sx     <= n_sx;
            r_sy     <= n_sy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_v4   <= 1'b0;
            r_dvld <= '0;
            r_vm   <= 1'b0;
            r_vo   <= 1'b0;
        end else if (adv) begin
            r_v1   <= i_in.valid;
            r_v2   <= r_v1;
            r_v3   <= r_v2;
            r_v4   <= r_v3;
            r_dvld <= {r_dvld[NST-1:0], r_v4};
            r_vm   <= r_dvld[NST];
            r_vo   <= r_vm;
        end
    end

    assign o_out.valid    = r_vo;
    assign o_out.relation = r_rel;
    assign o_out.first_x  = r_fx;
    assign o_out.first_y  = r_fy;
    assign o_out.second_x = r_sx;
    assign o_out.second_y = r_sy;
endmodule

@@ sv/spi_checker.sv @@
// Port-level checker for the segment intersection unit and its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module spi_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_ready,
    input logic                               i_out_valid,
    input logic                               i_out_ready,
    input logic [spi_pkg::REL_BITS-1:0]       i_relation,
    input logic signed [spi_pkg::OUT_BITS-1:0] i_first_x,
    input logic signed [spi_pkg::OUT_BITS-1:0] i_first_y,
    input logic signed [spi_pkg::OUT_BITS-1:0] i_second_x,
    input logic signed [spi_pkg::OUT_BITS-1:0] i_second_y
);
    // A relation code outside the three defined ones never leaves the block.
    `SPI_ASSERT_NOW(a_rel_code, i_clk, i_rst_n, i_out_valid,
        i_relation == spi_pkg::REL_NONE || i_relation == spi_pkg::REL_POINT ||
        i_relation == spi_pkg::REL_OVERLAP)
    // A disjoint result carries a zero first point.
    `SPI_ASSERT_NOW(a_none_zero, i_clk, i_rst_n,
        i_out_valid && i_relation == spi_pkg::REL_NONE,
        i_first_x == '0 && i_first_y == '0)
    // Only an overlap carries a second point.
    `SPI_ASSERT_NOW(a_second_zero, i_clk, i_rst_n,
        i_out_valid && i_relation != spi_pkg::REL_OVERLAP,
        i_second_x == '0 && i_second_y == '0)
    // Whenever the downstream side takes data, the block takes a new input.
    `SPI_ASSERT_NOW(a_in_flows, i_clk, i_rst_n, i_out_ready, i_in_ready)
    // A stalled result stays on the port.
    `SPI_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_first_x) && $stable(i_relation))
endmodule

bind segment_pair_intersect_unit spi_checker u_spi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_relation  (o_out.relation),
    .i_first_x   (o_out.first_x),
    .i_first_y   (o_out.first_y),
    .i_second_x  (o_out.second_x),
    .i_second_y  (o_out.second_y)
);
